[rtl/dim_pkg.sv]
package dim_pkg;

    // Array size and count width.
    localparam int NODES      = 16;
    localparam int COUNT_BITS = 16;

    // Field and register widths fixed by the interface.
    localparam int NODE_ID_W  = 4;
    localparam int MASK_BITS  = 16;
    localparam int MASK_IDX_W = $clog2(MASK_BITS);
    localparam int LIMIT_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 1;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 8;
    localparam int FRAC_BITS  = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_MASK  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_INDEX_Q8 = 1'd1;

    localparam logic [MASK_BITS-1:0] MASK_RESET  = '0;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET = 16'd256;

    // Derived datapath widths.
    localparam int NODE_W = $clog2(NODES);
    localparam int K_W    = $clog2(NODES + 1);
    localparam int S_W    = COUNT_BITS + NODE_W;
    localparam int SQ_W   = 2 * COUNT_BITS;
    localparam int Q_W    = SQ_W + NODE_W;
    localparam int KQ_W   = Q_W + K_W;
    localparam int SS_W   = 2 * S_W;
    localparam int LHS_W  = KQ_W + FRAC_BITS;
    localparam int SK_W   = S_W + K_W;
    localparam int RHS_W  = LIMIT_W + SK_W;
    localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ld_in;    // latch the input item
        logic rd_node;  // read the count of the event's node
        logic wr_inc;   // write back the incremented count, clear the sums
        logic walk;     // read the next node count into the sum pipeline
        logic mul1;     // form k*Q, S*S and S*k
        logic mul2;     // form both sides of the comparison
        logic ld_out;   // load the result register
    } t_dim_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;        // both flags set and node in range
        logic tgt;        // the event's node is a target
        logic walk_last;  // the walk is reading the last node
        logic pipe_busy;  // sum pipeline still holds data
        logic out_free;   // result register can take a new item
    } t_dim_sts;

    function automatic logic is_target(input logic [MASK_BITS-1:0] mask,
                                       input logic [NODE_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return (wide < 32'(MASK_BITS)) && mask[wide[MASK_IDX_W-1:0]];
    endfunction

endpackage

[rtl/dim_ctrl.sv]
module dim_ctrl
    import dim_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dim_sts i_sts,
    output t_dim_cmd o_cmd
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_RDN   = 8'b0000_0010,
        ST_INC   = 8'b0000_0100,
        ST_WALK  = 8'b0000_1000,
        ST_DRAIN = 8'b0001_0000,
        ST_MUL1  = 8'b0010_0000,
        ST_MUL2  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // No item is taken while reset is held.
                o_in_ready = i_rst_n;
                if (i_rst_n && i_in_valid) begin
                    o_cmd.ld_in = 1'b1;
                    n_state     = ST_RDN;
                end
            end
            ST_RDN: begin
                if (i_sts.hit) begin
                    o_cmd.rd_node = 1'b1;
                    n_state       = ST_INC;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_INC: begin
                o_cmd.wr_inc = 1'b1;
                n_state      = i_sts.tgt ? ST_WALK : ST_DONE;
            end
            ST_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = ST_MUL1;
                end
            end
            ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.ld_out = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/dim_dp.sv]
module dim_dp
    import dim_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [NODE_ID_W-1:0]  i_node_id,
    input  logic                  i_accepted,
    input  logic                  i_first_of_conn,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic                  o_counted,
    output logic                  o_checked,
    output logic                  o_over_limit,
    output logic                  o_violated,
    input  t_dim_cmd              i_cmd,
    output t_dim_sts              o_sts
);

    logic [MASK_BITS-1:0]  r_mask;
    logic [LIMIT_W-1:0]    r_limit;

    logic [NODE_W-1:0]     r_node;
    logic                  r_hit;
    logic                  r_tgt;

    logic [COUNT_BITS-1:0] r_mem [NODES];
    logic [NODES-1:0]      r_valid;
    logic [COUNT_BITS-1:0] r_rd_data;
    logic [NODE_W-1:0]     rd_addr;
    logic [COUNT_BITS-1:0] inc_count;

    logic [NODE_W-1:0]     r_idx;
    logic                  r_v1;
    logic                  r_tgt1;
    logic                  r_v2;
    logic [SQ_W-1:0]       r_sq;
    logic [K_W-1:0]        r_k;
    logic [S_W-1:0]        r_s;
    logic [Q_W-1:0]        r_q;

    logic [KQ_W-1:0]       r_kq;
    logic [SS_W-1:0]       r_ss;
    logic [SK_W-1:0]       r_sk;
    logic [LHS_W-1:0]      r_lhs;
    logic [RHS_W-1:0]      r_rhs;

    logic                  r_out_valid;
    logic                  r_counted;
    logic                  r_checked;
    logic                  r_over;
    logic                  r_viol;
    logic                  in_range;
    logic                  over_now;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= MASK_RESET;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_TARGET_MASK:  r_mask  <= i_cfg_wdata[MASK_BITS-1:0];
                REG_MAX_INDEX_Q8: r_limit <= i_cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Input item latch.
    assign in_range = 32'(i_node_id) < 32'(NODES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
            r_tgt <= 1'b0;
        end else if (i_cmd.ld_in) begin
            r_hit <= i_accepted && i_first_of_conn && in_range;
            r_tgt <= in_range && is_target(r_mask, NODE_W'(i_node_id));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_node <= NODE_W'(i_node_id);
        end
    end

    // Count memory: one write port, one registered read port.
    // An entry never written since reset reads as zero.
    assign rd_addr   = i_cmd.walk ? r_idx : r_node;
    assign inc_count = (r_rd_data == COUNT_MAX) ? r_rd_data : r_rd_data + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_inc) begin
            r_mem[r_node] <= inc_count;
        end
        if (i_cmd.rd_node || i_cmd.walk) begin
            r_rd_data <= r_valid[rd_addr] ? r_mem[rd_addr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.wr_inc) begin
            r_valid[r_node] <= 1'b1;
        end
    end

    // Walk over all nodes: read, square, accumulate.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
        end else begin
            if (i_cmd.wr_inc) begin
                r_idx <= '0;
            end else if (i_cmd.walk) begin
                r_idx <= NODE_W'(r_idx + 1'b1);
            end
            r_v1 <= i_cmd.walk;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tgt1 <= is_target(r_mask, r_idx);
        r_sq   <= r_tgt1 ? SQ_W'(r_rd_data) * SQ_W'(r_rd_data) : '0;
        if (i_cmd.wr_inc) begin
            r_k <= '0;
            r_s <= '0;
            r_q <= '0;
        end else begin
            if (r_v1 && r_tgt1) begin
                r_k <= K_W'(r_k + 1'b1);
                r_s <= r_s + S_W'(r_rd_data);
            end
            if (r_v2) begin
                r_q <= r_q + Q_W'(r_sq);
            end
        end
    end

    // Two multiply stages, then the compare at result time.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_kq <= KQ_W'(r_k) * KQ_W'(r_q);
            r_ss <= SS_W'(r_s) * SS_W'(r_s);
            r_sk <= SK_W'(r_s) * SK_W'(r_k);
        end
        if (i_cmd.mul2) begin
            r_lhs <= {KQ_W'(r_kq - KQ_W'(r_ss)), {FRAC_BITS{1'b0}}};
            r_rhs <= RHS_W'(r_limit) * RHS_W'(r_sk);
        end
    end

    assign over_now = r_hit && r_tgt && (CMP_W'(r_lhs) > CMP_W'(r_rhs));

    // Result register and sticky flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_viol      <= 1'b0;
        end else begin
            if (i_cmd.ld_out) begin
                r_out_valid <= 1'b1;
                r_viol      <= r_viol || over_now;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_out) begin
            r_counted <= r_hit;
            r_checked <= r_hit && r_tgt;
            r_over    <= over_now;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_counted    = r_counted;
    assign o_checked    = r_checked;
    assign o_over_limit = r_over;
    assign o_violated   = r_viol;

    assign o_sts.hit       = r_hit;
    assign o_sts.tgt       = r_tgt;
    assign o_sts.walk_last = r_idx == NODE_W'(NODES - 1);
    assign o_sts.pipe_busy = r_v1 || r_v2;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

endmodule

[rtl/dispersion_index_monitor.sv]
// Dispersion index monitor. Each input item is a delivery event (node, accepted,
// first-of-connection) and produces exactly one result item. An event with both
// flags set on a node in range bumps that node's saturating arrival count; if the
// node is in the target set, the block then walks all node counts to form k, the
// sum S and the sum of squares Q over the targets, and flags the event when
// 256*(k*Q - S*S) > T*S*k, with T the limit in unsigned Q8.8. Any flagged event
// sets the sticky violated bit, which every result carries. The block works on one
// item at a time. An event that counts nothing goes from the input latch straight to
// the result register; a counted non-target event first reads its node's count and
// writes back the incremented value; a counted target event then also walks the count
// memory, one read per cycle, drains the sum pipeline and takes two multiply steps.
// The input is ready again in the cycle after the result is loaded, so a new item is
// only taken once the last one has been loaded into the output register. A new item
// may be accepted while the previous result still waits in the output register; the
// block then stalls before loading the next result until that register is free.
// Configuration writes are taken at any time but must only be issued while the block
// is idle. After reset all counts read as zero, the target mask is empty and the
// limit is 1.0 (256).
module dispersion_index_monitor
    import dim_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // Configuration write port: index 0 is target_mask, index 1 is max_index_q8.
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,

    // Event stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata from bit 0: node_id[3:0], accepted, first_of_conn, two zero bits.
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,

    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata from bit 0: counted, checked, over_limit, violated, four zero bits.
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_dim_cmd cmd;
    t_dim_sts sts;
    logic     counted;
    logic     checked;
    logic     over_limit;
    logic     violated;

    // The controller sequences one item: latch, read count, write back, walk the
    // counts, drain the sum pipeline, two multiply steps, then load the result register.
    dim_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds the configuration, the count memory, the sum
    // pipeline, the multipliers and the result register.
    dim_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_node_id       (s_axis_tdata[NODE_ID_W-1:0]),
        .i_accepted      (s_axis_tdata[NODE_ID_W]),
        .i_first_of_conn (s_axis_tdata[NODE_ID_W+1]),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_counted       (counted),
        .o_checked       (checked),
        .o_over_limit    (over_limit),
        .o_violated      (violated),
        .i_cmd           (cmd),
        .o_sts           (sts)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - 4){1'b0}}, violated, over_limit, checked, counted};

endmodule

[bench/dispersion_index_monitor_tb.sv]
// Testbench for dispersion_index_monitor.
//
// The bench sends delivery events through the input stream and reads result items from the
// output stream. It keeps its own copy of the per-node arrival counts, the sticky violation
// flag and both configuration registers. For every accepted event it works out the result
// that the block must return. The expected results wait in a queue, and the result check
// compares each returned result with the oldest entry, one field at a time.
//
// The run has three parts:
//   1. A short directed table. It covers the flag combinations that count nothing, node 0 and
//      node 15, a target set whose counts are equal (zero variance), a limit of zero, the
//      sticky flag, a one-node target set and a node outside the target set.
//   2. Random phases. Each phase starts from a new register setting: full, empty and
//      single-node target sets, and limits of 0, 1.0 and the largest value. Most events
//      carry both flags and lean on a hot node, so that the dispersion moves around the limit.
//   3. A few target checks around one node: alone and together with other nodes.
//
// Both sides of the block pause at random. The result side also holds off once for a long
// stretch while events keep arriving, so that the block fills up and stops taking input.
module dispersion_index_monitor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dim_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 5;
    localparam int PHASES           = 8;
    localparam int EVENTS_PER_PHASE = 160;
    // The settle time allows for the walk of a counted target event over all NODES counts
    // and adds some margin.
    localparam int SETTLE_CYCLES    = NODES + 20;
    // The watchdog fires after this many cycles in which neither stream moves an item.
    // The longest legal silence is the long hold on the result side plus one walk.
    localparam int STALL_LIMIT      = 3000;
    localparam int LONG_HOLD_AT     = 450;
    localparam int LONG_HOLD_CYCLES = 300;

    // Input item fields. The packed order puts node_id in the lowest bits, the same
    // order as the fields in tdata.
    typedef struct packed {
        logic                 first_of_conn;
        logic                 accepted;
        logic [NODE_ID_W-1:0] node_id;
    } t_delivery;

    // Result item fields. The packed order puts counted in bit 0.
    typedef struct packed {
        logic violated;
        logic over_limit;
        logic checked;
        logic counted;
    } t_result_flags;

    typedef enum logic {ROW_EVENT, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_ADDR_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [NODE_ID_W-1:0]  node;
        logic                  acc;
        logic                  first;
        bit                    typed;  // use the flags below instead of the prediction
        t_result_flags         flags;  // {violated, over_limit, checked, counted}
    } t_stim_row;

    // Directed table. A row with typed set carries an expectation that can be read off
    // the behavior directly. Every other row takes its expectation from the predictor.
    localparam int DIRECTED_ROWS = 19;
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        // Out of reset: events that lack one of the flags count nothing.
        '{ROW_EVENT, REG_TARGET_MASK,  16'h0000, 4'd0,  1'b0, 1'b0, 1'b1, 4'b0000},
        '{ROW_EVENT, REG_TARGET_MASK,  16'h0000, 4'd15, 1'b1, 1'b0, 1'b1, 4'b0000},
        '{ROW_EVENT, REG_TARGET_MASK,  16'h0000, 4'd7,  1'b0, 1'b1, 1'b1, 4'b0000},
        // The target set is empty after reset, so these events are counted only.
        '{ROW_EVENT, REG_TARGET_MASK,  16'h0000, 4'd0,  1'b1, 1'b1, 1'b1, 4'b0001},
        '{ROW_EVENT, REG_TARGET_MASK,  16'h0000, 4'd15, 1'b1, 1'b1, 1'b1, 4'b0001},
        // Targets 0 and 1. Equal counts give zero variance, so the event is within the limit.
        '{ROW_WRITE, REG_TARGET_MASK,  16'h0003, 4'd0,  1'b0, 1'b0, 1'b0, 4'b0000},
        '{ROW_EVENT, REG_TARGET_MASK,  16'h0000, 4'd1,  1'b1, 1'b1, 1'b1, 4'b0011},
        '{ROW_EVENT, REG_TARGET_MASK,  16'h0000, 4'd1,  1'b1, 1'b1, 1'b0, 4'b0000},
        // A limit of zero flags any nonzero spread and sets the sticky bit.
        '{ROW_WRITE, REG_MAX_INDEX_Q8, 16'h0000, 4'd0,  1'b0, 1'b0, 1'b0, 4'b0000},
        '{ROW_EVENT, REG_TARGET_MASK,  16'h0000, 4'd1,  1'b1, 1'b1, 1'b1, 4'b1111},
        '{ROW_EVENT, REG_TARGET_MASK,  16'h0000, 4'd0,  1'b0, 1'b1, 1'b1, 4'b1000},
        // All nodes are targets and the limit is at its largest value.
        '{ROW_WRITE, REG_TARGET_MASK,  16'hFFFF, 4'd0,  1'b0, 1'b0, 1'b0, 4'b0000},
        '{ROW_WRITE, REG_MAX_INDEX_Q8, 16'hFFFF, 4'd0,  1'b0, 1'b0, 1'b0, 4'b0000},
        '{ROW_EVENT, REG_TARGET_MASK,  16'h0000, 4'd8,  1'b1, 1'b1, 1'b0, 4'b0000},
        '{ROW_EVENT, REG_TARGET_MASK,  16'h0000, 4'd15, 1'b1, 1'b1, 1'b0, 4'b0000},
        // Node 15 is the only target, so the index is tested over a single count.
        '{ROW_WRITE, REG_TARGET_MASK,  16'h8000, 4'd0,  1'b0, 1'b0, 1'b0, 4'b0000},
        '{ROW_EVENT, REG_TARGET_MASK,  16'h0000, 4'd15, 1'b1, 1'b1, 1'b0, 4'b0000},
        '{ROW_EVENT, REG_TARGET_MASK,  16'h0000, 4'd14, 1'b1, 1'b1, 1'b1, 4'b1001},
        '{ROW_EVENT, REG_TARGET_MASK,  16'h0000, 4'd10, 1'b1, 1'b0, 1'b1, 4'b1000}
    };

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // tdata from bit 0: node_id[3:0], accepted, first_of_conn, two zero bits.
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // tdata from bit 0: counted, checked, over_limit, violated, four zero bits.
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // The bench's copy of the block state and registers.
    logic [COUNT_BITS-1:0] node_count [NODES];
    logic                  sticky_violation = 1'b0;
    logic [MASK_BITS-1:0]  target_set       = MASK_RESET;
    logic [LIMIT_W-1:0]    limit_q8         = LIMIT_RESET;

    t_result_flags expected_flags [$];
    int  mismatches     = 0;
    int  results_seen   = 0;
    int  idle_cycles    = 0;
    bit  steady_run     = 1'b0;  // no idling on either side while set
    bit  long_hold_done = 1'b0;

    dispersion_index_monitor u_top (
        .i_clk,
        .i_rst_n,
        .i_cfg_we,
        .i_cfg_addr,
        .i_cfg_wdata,
        .s_axis_tvalid,
        .s_axis_tready,
        .s_axis_tdata,
        .m_axis_tvalid,
        .m_axis_tready,
        .m_axis_tdata
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    initial begin
        foreach (node_count[n]) node_count[n] = '0;
    end

    // Updates the count for one event and returns the result that the block must give.
    // The products stay below 2^50 for 16 nodes of 16 bits, so 64 bits hold them exactly.
    // k*Q is never below S*S, so the difference cannot wrap.
    function automatic t_result_flags predict_delivery(input t_delivery ev);
        t_result_flags res;
        logic [63:0]   k, s, q, spread, bound;
        res = '0;
        if (ev.accepted && ev.first_of_conn) begin
            res.counted = 1'b1;
            if (node_count[ev.node_id] != COUNT_MAX) begin
                node_count[ev.node_id] = node_count[ev.node_id] + 1'b1;
            end
            if (target_set[ev.node_id]) begin
                res.checked = 1'b1;
                k = '0;
                s = '0;
                q = '0;
                for (int n = 0; n < NODES; n++) begin
                    if (n < MASK_BITS && target_set[n]) begin
                        k += 1;
                        s += 64'(node_count[n]);
                        q += 64'(node_count[n]) * 64'(node_count[n]);
                    end
                end
                spread = (k * q - s * s) << FRAC_BITS;
                bound  = 64'(limit_q8) * s * k;
                if (spread > bound) begin
                    res.over_limit   = 1'b1;
                    sticky_violation = 1'b1;
                end
            end
        end
        res.violated = sticky_violation;
        return res;
    endfunction

    // Length of a pause: mostly none, sometimes a few cycles, now and then a long one.
    function automatic int pick_gap(input int short_pct, input int long_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < long_pct) return $urandom_range(10, 40);
        if (roll < long_pct + short_pct) return $urandom_range(1, 3);
        return 0;
    endfunction

    // About three quarters of the events carry both flags. They favor a hot node and the
    // current targets, so the counts spread unevenly. The rest take any flag combination.
    function automatic t_delivery random_event(input logic [NODE_ID_W-1:0] hot);
        t_delivery ev;
        int        roll;
        ev.node_id = NODE_ID_W'($urandom_range(0, NODES - 1));
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
            ev.accepted      = 1'b1;
            ev.first_of_conn = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 35) begin
                ev.node_id = hot;
            end else if (roll < 70 && target_set != '0) begin
                while (!target_set[ev.node_id]) begin
                    ev.node_id = NODE_ID_W'($urandom_range(0, NODES - 1));
                end
            end
        end else begin
            ev.accepted      = 1'($urandom_range(0, 1));
            ev.first_of_conn = 1'($urandom_range(0, 1));
        end
        return ev;
    endfunction

    // Offers one event and waits for the block to take it. Once the event is accepted,
    // its expected result goes into the queue. tvalid stays high when no gap follows,
    // so the next event can go in without a pause.
    task automatic send_event(input t_delivery ev, input bit typed,
                              input t_result_flags typed_flags);
        t_result_flags predicted;
        int            gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'(ev);
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = predict_delivery(ev);
        expected_flags.push_back(typed ? typed_flags : predicted);
        gap = steady_run ? 0 : pick_gap(30, 4);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stops offering events and waits until every expected result has come back. Then it
    // waits out the longest walk, so the block is idle when this task returns.
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (expected_flags.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        settle_block();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_TARGET_MASK) begin
            target_set = value;
        end else if (idx == REG_MAX_INDEX_Q8) begin
            limit_q8 = value;
        end
    endtask

    function automatic void check_flag(input string name, input logic want, input logic got);
        if (got !== want) begin
            $error("%s: expected %0b, got %0b", name, want, got);
            mismatches++;
        end
    endfunction

    // Result check. Every result item taken from the block must match the oldest
    // expectation.
    always @(posedge i_clk) begin : result_check
        t_result_flags want;
        t_result_flags got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            got = m_axis_tdata[3:0];
            if (expected_flags.size() == 0) begin
                $error("result item %0h arrived with nothing expected", m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_flags.pop_front();
                check_flag("counted", want.counted, got.counted);
                check_flag("checked", want.checked, got.checked);
                check_flag("over_limit", want.over_limit, got.over_limit);
                check_flag("violated", want.violated, got.violated);
            end
        end
    end

    // Result side. It pauses at random outside the steady phases. Once, after a few
    // hundred results, it holds off for a long stretch. The event side keeps sending in
    // the meantime, so the output register and the datapath fill up and tready drops.
    initial begin : result_sink
        int stall;
        stall = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (stall == 0 && !long_hold_done && results_seen >= LONG_HOLD_AT) begin
                long_hold_done = 1'b1;
                stall = LONG_HOLD_CYCLES;
            end else if (stall == 0 && !steady_run) begin
                stall = pick_gap(15, 1);
            end
            if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog. A run in which nothing moves for too long has hung.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [NODE_ID_W-1:0] hot;
        logic [NODE_ID_W-1:0] focus_node;
        logic [NODE_ID_W-1:0] buddy;
        int                   counted_events;
        t_delivery            ev;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_WRITE) begin
                write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_val);
            end else begin
                ev = {directed_rows[r].first, directed_rows[r].acc, directed_rows[r].node};
                send_event(ev, directed_rows[r].typed, directed_rows[r].flags);
            end
        end

        // Random phases. Each one starts by writing both registers. Every third phase
        // runs without idling.
        for (int phase = 0; phase < PHASES; phase++) begin
            steady_run = (phase % 3 == 1);
            hot = NODE_ID_W'($urandom_range(0, NODES - 1));
            case (phase)
                0: begin
                    write_reg(REG_TARGET_MASK, '1);
                    write_reg(REG_MAX_INDEX_Q8, LIMIT_RESET);
                end
                1: begin
                    write_reg(REG_TARGET_MASK, '0);
                    write_reg(REG_MAX_INDEX_Q8, CFG_DATA_W'($urandom));
                end
                2: begin
                    // A single target can never spread, even with a zero limit.
                    write_reg(REG_TARGET_MASK, CFG_DATA_W'(1) << hot);
                    write_reg(REG_MAX_INDEX_Q8, '0);
                end
                3: begin
                    write_reg(REG_TARGET_MASK, CFG_DATA_W'($urandom));
                    write_reg(REG_MAX_INDEX_Q8, '1);
                end
                4: begin
                    write_reg(REG_TARGET_MASK, CFG_DATA_W'($urandom));
                    write_reg(REG_MAX_INDEX_Q8, CFG_DATA_W'($urandom_range(128, 1024)));
                end
                5: begin
                    write_reg(REG_TARGET_MASK, '1);
                    write_reg(REG_MAX_INDEX_Q8, '0);
                end
                6: begin
                    write_reg(REG_TARGET_MASK, CFG_DATA_W'($urandom & $urandom));
                    write_reg(REG_MAX_INDEX_Q8, CFG_DATA_W'(512));
                end
                default: begin
                    write_reg(REG_TARGET_MASK, CFG_DATA_W'($urandom));
                    write_reg(REG_MAX_INDEX_Q8, CFG_DATA_W'($urandom));
                end
            endcase
            counted_events = 0;
            while (counted_events < EVENTS_PER_PHASE) begin
                ev = random_event(hot);
                if (ev.accepted && ev.first_of_conn) counted_events++;
                send_event(ev, 1'b0, '0);
            end
        end

        // Target checks around one node: first with all nodes as targets, then alone,
        // and then with one neighbor under a zero limit.
        steady_run = 1'b0;
        focus_node = NODE_ID_W'($urandom_range(0, NODES - 1));
        buddy      = focus_node + 1'b1;
        ev         = {1'b1, 1'b1, focus_node};
        write_reg(REG_TARGET_MASK, '1);
        write_reg(REG_MAX_INDEX_Q8, '1);
        repeat (20) send_event(random_event(focus_node), 1'b0, '0);
        write_reg(REG_TARGET_MASK, CFG_DATA_W'(1) << focus_node);
        write_reg(REG_MAX_INDEX_Q8, CFG_DATA_W'($urandom));
        repeat (4) send_event(ev, 1'b0, '0);
        write_reg(REG_TARGET_MASK,
                  (CFG_DATA_W'(1) << focus_node) | (CFG_DATA_W'(1) << buddy));
        write_reg(REG_MAX_INDEX_Q8, '0);
        repeat (4) begin
            send_event(ev, 1'b0, '0);
            send_event({1'b1, 1'b1, buddy}, 1'b0, '0);
        end

        settle_block();
        if (mismatches == 0 && expected_flags.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
